@@ design/midpoint_line_clipper_top_defines.svh @@
// Assertion macros for the midpoint line clipper.
// Used by midpoint_line_clipper_top; needs clk_i and rst_ni in scope.
`ifndef MIDPOINT_LINE_CLIPPER_TOP_DEFINES_SVH
`define MIDPOINT_LINE_CLIPPER_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define MLC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define MLC_ASSERT_IMPL(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) pre |-> post) else $error(msg);
`else
`define MLC_ASSERT(lbl, prop, msg)
`define MLC_ASSERT_IMPL(lbl, pre, post, msg)
`endif
`endif

@@ design/mlc_pkg.sv @@
// Package of the midpoint line clipper: types, constants and state codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mlc_pkg;

  localparam int CoordBits   = 16;
  localparam int StackDepth  = 34;
  localparam int BisectLimit = 2 * CoordBits + 8;

  typedef logic signed [CoordBits-1:0] coord_t;

  localparam coord_t ResetMinX = coord_t'(0);
  localparam coord_t ResetMinY = coord_t'(0);
  localparam coord_t ResetMaxX = coord_t'(639);
  localparam coord_t ResetMaxY = coord_t'(479);

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CfgMinX = 2'd0,
    CfgMinY = 2'd1,
    CfgMaxX = 2'd2,
    CfgMaxY = 2'd3
  } cfg_idx_e;

  // Sequencer states.
  typedef enum logic [1:0] {
    StIdle,
    StLeaf,
    StBisect,
    StPop
  } state_e;

  typedef struct packed {
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
  } in_item_t;

  typedef struct packed {
    logic   visible;
    coord_t clipped_start_x;
    coord_t clipped_start_y;
    coord_t clipped_end_x;
    coord_t clipped_end_y;
  } out_item_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } point_t;

endpackage

`default_nettype wire

@@ design/mlc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module mlc_ram #(
  parameter int Width = 8,
  parameter int Depth = 4
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ design/midpoint_line_clipper_top.sv @@
// A line is worked off as leaf segments, stack pops and border bisection probes;
// the result word is registered and strobed in the cycle after the last step.
// Throughput: one line at a time; a new line is taken in the cycle its predecessor's
// result is strobed. The depth-first split stack and the shared midpoint adder set this.
// Reset is asynchronous: rectangle returns to (0,0)-(639,479), sequencer goes idle.
// The receiver cannot stall: each result word is strobed on res_valid_o for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none
`include "midpoint_line_clipper_top_defines.svh"

module midpoint_line_clipper_top #(
  parameter int STACK_DEPTH = mlc_pkg::StackDepth
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start,
  output logic                             busy,
  input  wire mlc_pkg::in_item_t           in_item_i,
  output logic                             res_valid_o,
  output mlc_pkg::out_item_t               res_o,
  input  wire logic                        cfg_we_i,
  input  wire logic [1:0]                  cfg_idx_i,
  input  wire logic [mlc_pkg::CoordBits-1:0] cfg_data_i
);

  localparam int CB = mlc_pkg::CoordBits;
  localparam int DW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int EW = 4 * CB + DW;
  localparam int NW = $clog2(mlc_pkg::BisectLimit);

  typedef struct packed {
    logic ok;
    mlc_pkg::coord_t a1;
    mlc_pkg::coord_t a2;
  } axis_t;

  // Midpoint truncated toward zero, one guard bit wide.
  function automatic mlc_pkg::coord_t half_sum(mlc_pkg::coord_t a, mlc_pkg::coord_t b);
    logic signed [CB:0] s;
    logic signed [CB:0] t;
    s = {a[CB-1], a} + {b[CB-1], b};
    t = s + {{CB{1'b0}}, s[CB]};
    half_sum = t[CB:1];
  endfunction

  // Clamp an axis-parallel line: f is the fixed coordinate.
  function automatic axis_t axis_clip(mlc_pkg::coord_t f, mlc_pkg::coord_t fmin,
                                      mlc_pkg::coord_t fmax, mlc_pkg::coord_t a1,
                                      mlc_pkg::coord_t a2, mlc_pkg::coord_t amin,
                                      mlc_pkg::coord_t amax);
    axis_t r;
    r.ok = 1'b1;
    r.a1 = a1;
    r.a2 = a2;
    if (f < fmin || f > fmax) begin
      r.ok = 1'b0;
    end else if (a1 < a2) begin
      if (a1 > amax || a2 < amin) r.ok = 1'b0;
      if (a1 < amin) r.a1 = amin;
      if (a2 > amax) r.a2 = amax;
    end else begin
      if (a2 > amax || a1 < amin) r.ok = 1'b0;
      if (a2 < amin) r.a2 = amin;
      if (a1 > amax) r.a1 = amax;
    end
    axis_clip = r;
  endfunction

  mlc_pkg::coord_t min_x_q, min_y_q, max_x_q, max_y_q;

  function automatic logic [3:0] outcode(mlc_pkg::point_t p, mlc_pkg::coord_t lx,
                                         mlc_pkg::coord_t hx, mlc_pkg::coord_t ly,
                                         mlc_pkg::coord_t hy);
    outcode = {p.y > hy, p.y < ly, p.x > hx, p.x < lx};
  endfunction

  mlc_pkg::state_e state_q, state_d;
  mlc_pkg::point_t cur_a_q, cur_a_d, cur_b_q, cur_b_d;
  mlc_pkg::point_t in_q, in_d, out_q, out_d, mid_q, mid_d;
  mlc_pkg::point_t ra_q, ra_d, rb_q, rb_d;
  mlc_pkg::in_item_t orig_q, orig_d;
  logic [DW-1:0] cur_d_q, cur_d_d, sp_q, sp_d;
  logic [NW-1:0] cnt_q, cnt_d;
  logic bis_a_q, bis_a_d, vis_q, vis_d;
  logic res_valid_q, res_valid_d;
  mlc_pkg::out_item_t res_q, res_d;

  // Stack port signals.
  logic          st_we, st_re;
  logic [EW-1:0] st_wdata, st_rdata;
  logic [DW-1:0] sp_m1;

  // Leaf classification and bisection step.
  logic [3:0] c1, c2, cm;
  axis_t ax_v, ax_h;
  mlc_pkg::point_t m, op1, op2, in_n, out_n;
  logic leaf_done, leaf_vis, leaf_split, leaf_bis, bis_done;
  mlc_pkg::point_t leaf_a, leaf_b;
  logic fin, fin_vis;
  mlc_pkg::point_t fin_a, fin_b;

  assign c1 = outcode(cur_a_q, min_x_q, max_x_q, min_y_q, max_y_q);
  assign c2 = outcode(cur_b_q, min_x_q, max_x_q, min_y_q, max_y_q);
  assign cm = outcode(mid_q, min_x_q, max_x_q, min_y_q, max_y_q);
  assign in_n  = (cm == 4'd0) ? mid_q : in_q;
  assign out_n = (cm != 4'd0) ? mid_q : out_q;

  // Shared midpoint unit: split point in a leaf, next probe in bisection.
  assign op1 = (state_q == mlc_pkg::StBisect) ? in_n : cur_a_q;
  assign op2 = (state_q == mlc_pkg::StBisect) ? out_n : cur_b_q;
  assign m.x = half_sum(op1.x, op2.x);
  assign m.y = half_sum(op1.y, op2.y);

  assign ax_v = axis_clip(cur_a_q.x, min_x_q, max_x_q, cur_a_q.y, cur_b_q.y,
                          min_y_q, max_y_q);
  assign ax_h = axis_clip(cur_a_q.y, min_y_q, max_y_q, cur_a_q.x, cur_b_q.x,
                          min_x_q, max_x_q);

  // Decide what the current leaf segment does this cycle.
  always_comb begin
    leaf_done  = 1'b0;
    leaf_vis   = 1'b0;
    leaf_split = 1'b0;
    leaf_bis   = 1'b0;
    leaf_a     = cur_a_q;
    leaf_b     = cur_b_q;
    if (cur_a_q.x == cur_b_q.x) begin
      leaf_done = 1'b1;
      leaf_vis  = ax_v.ok;
      leaf_a.y  = ax_v.a1;
      leaf_b.y  = ax_v.a2;
    end else if (cur_a_q.y == cur_b_q.y) begin
      leaf_done = 1'b1;
      leaf_vis  = ax_h.ok;
      leaf_a.x  = ax_h.a1;
      leaf_b.x  = ax_h.a2;
    end else if (c1 == 4'd0 && c2 == 4'd0) begin
      leaf_done = 1'b1;
      leaf_vis  = 1'b1;
    end else if ((c1 & c2) != 4'd0) begin
      leaf_done = 1'b1;
    end else if (c1 != 4'd0 && c2 != 4'd0) begin
      if (m == cur_a_q || m == cur_b_q || cur_d_q >= DW'(STACK_DEPTH)) begin
        leaf_done = 1'b1;
      end else begin
        leaf_split = 1'b1;
      end
    end else begin
      leaf_bis = 1'b1;
    end
  end

  assign bis_done = (m == mid_q) || (cnt_q == NW'(mlc_pkg::BisectLimit - 1));

  // A finished leaf, from the classifier or from the end of a bisection.
  always_comb begin
    fin     = 1'b0;
    fin_vis = leaf_vis;
    fin_a   = leaf_a;
    fin_b   = leaf_b;
    if (state_q == mlc_pkg::StLeaf) begin
      fin = leaf_done;
    end else if (state_q == mlc_pkg::StBisect) begin
      fin     = bis_done;
      fin_vis = 1'b1;
      fin_a   = bis_a_q ? in_n : cur_a_q;
      fin_b   = bis_a_q ? cur_b_q : in_n;
    end
  end

  assign sp_m1 = sp_q - DW'(1);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mlc_pkg::StIdle: begin
        if (start) state_d = mlc_pkg::StLeaf;
      end
      mlc_pkg::StLeaf: begin
        if (leaf_bis) begin
          state_d = mlc_pkg::StBisect;
        end else if (fin) begin
          state_d = (sp_q == '0) ? mlc_pkg::StIdle : mlc_pkg::StPop;
        end
      end
      mlc_pkg::StBisect: begin
        if (fin) state_d = (sp_q == '0) ? mlc_pkg::StIdle : mlc_pkg::StPop;
      end
      mlc_pkg::StPop: state_d = mlc_pkg::StLeaf;
      default: state_d = mlc_pkg::StIdle;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    busy     = (state_q != mlc_pkg::StIdle);
    st_we    = (state_q == mlc_pkg::StLeaf) && leaf_split;
    st_re    = fin && (sp_q != '0);
    st_wdata = {m.x, m.y, cur_b_q.x, cur_b_q.y, cur_d_q + DW'(1)};
  end

  // Datapath next values.
  always_comb begin
    cur_a_d     = cur_a_q;
    cur_b_d     = cur_b_q;
    cur_d_d     = cur_d_q;
    in_d        = in_q;
    out_d       = out_q;
    mid_d       = mid_q;
    cnt_d       = cnt_q;
    bis_a_d     = bis_a_q;
    orig_d      = orig_q;
    sp_d        = sp_q;
    vis_d       = vis_q;
    ra_d        = ra_q;
    rb_d        = rb_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    if (state_q == mlc_pkg::StIdle && start) begin
      orig_d    = in_item_i;
      cur_a_d.x = in_item_i.start_x;
      cur_a_d.y = in_item_i.start_y;
      cur_b_d.x = in_item_i.end_x;
      cur_b_d.y = in_item_i.end_y;
      cur_d_d   = '0;
      sp_d      = '0;
      vis_d     = 1'b0;
    end
    if (state_q == mlc_pkg::StLeaf && leaf_split) begin
      cur_b_d = m;
      cur_d_d = cur_d_q + DW'(1);
      sp_d    = sp_q + DW'(1);
    end
    if (state_q == mlc_pkg::StLeaf && leaf_bis) begin
      bis_a_d = (c1 != 4'd0);
      in_d    = (c1 != 4'd0) ? cur_b_q : cur_a_q;
      out_d   = (c1 != 4'd0) ? cur_a_q : cur_b_q;
      mid_d   = m;
      cnt_d   = '0;
    end
    if (state_q == mlc_pkg::StBisect) begin
      in_d  = in_n;
      out_d = out_n;
      mid_d = m;
      cnt_d = cnt_q + NW'(1);
    end
    if (state_q == mlc_pkg::StPop) begin
      {cur_a_d.x, cur_a_d.y, cur_b_d.x, cur_b_d.y, cur_d_d} = st_rdata;
    end
    // Leftmost visible piece gives the start, rightmost the end.
    if (fin) begin
      if (fin_vis) begin
        vis_d = 1'b1;
        rb_d  = fin_b;
        if (!vis_q) ra_d = fin_a;
      end
      if (sp_q == '0) begin
        res_valid_d = 1'b1;
        if (vis_q || fin_vis) begin
          res_d.visible         = 1'b1;
          res_d.clipped_start_x = vis_q ? ra_q.x : fin_a.x;
          res_d.clipped_start_y = vis_q ? ra_q.y : fin_a.y;
          res_d.clipped_end_x   = fin_vis ? fin_b.x : rb_q.x;
          res_d.clipped_end_y   = fin_vis ? fin_b.y : rb_q.y;
        end else begin
          res_d.visible         = 1'b0;
          res_d.clipped_start_x = orig_q.start_x;
          res_d.clipped_start_y = orig_q.start_y;
          res_d.clipped_end_x   = orig_q.end_x;
          res_d.clipped_end_y   = orig_q.end_y;
        end
      end else begin
        sp_d = sp_m1;
      end
    end
  end

  // Split stack of pending right halves.
  mlc_ram #(
    .Width(EW),
    .Depth(STACK_DEPTH)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (sp_q[AW-1:0]),
    .wdata_i (st_wdata),
    .re_i    (st_re),
    .raddr_i (sp_m1[AW-1:0]),
    .rdata_o (st_rdata)
  );

  // Control registers and configuration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mlc_pkg::StIdle;
      sp_q        <= '0;
      vis_q       <= 1'b0;
      res_valid_q <= 1'b0;
      min_x_q     <= mlc_pkg::ResetMinX;
      min_y_q     <= mlc_pkg::ResetMinY;
      max_x_q     <= mlc_pkg::ResetMaxX;
      max_y_q     <= mlc_pkg::ResetMaxY;
    end else begin
      state_q     <= state_d;
      sp_q        <= sp_d;
      vis_q       <= vis_d;
      res_valid_q <= res_valid_d;
      if (cfg_we_i) begin
        unique case (mlc_pkg::cfg_idx_e'(cfg_idx_i))
          mlc_pkg::CfgMinX: min_x_q <= cfg_data_i;
          mlc_pkg::CfgMinY: min_y_q <= cfg_data_i;
          mlc_pkg::CfgMaxX: max_x_q <= cfg_data_i;
          mlc_pkg::CfgMaxY: max_y_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    cur_a_q <= cur_a_d;
    cur_b_q <= cur_b_d;
    cur_d_q <= cur_d_d;
    in_q    <= in_d;
    out_q   <= out_d;
    mid_q   <= mid_d;
    cnt_q   <= cnt_d;
    bis_a_q <= bis_a_d;
    orig_q  <= orig_d;
    ra_q    <= ra_d;
    rb_q    <= rb_d;
    res_q   <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  `MLC_ASSERT(a_sp_bound, sp_q <= DW'(STACK_DEPTH), "split stack overran its depth")
  `MLC_ASSERT_IMPL(a_bis_cnt, state_q == mlc_pkg::StBisect,
    cnt_q < NW'(mlc_pkg::BisectLimit), "bisection ran past its step limit")
  `MLC_ASSERT_IMPL(a_start, start && !busy, ##1 state_q == mlc_pkg::StLeaf,
    "accepted line did not enter leaf processing")
  `MLC_ASSERT_IMPL(a_res_src, res_valid_q, $past(busy) && !busy,
    "result strobed without a finished line")

endmodule

`default_nettype wire

@@ verif/midpoint_line_clipper_top_tb.sv @@
// Self-checking testbench for the midpoint line clipper: directed and random lines
// against several clip rectangles, checked by a behavioral predictor. Needs mlc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module midpoint_line_clipper_top_tb;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          start = 1'b0;
  logic                          busy;
  mlc_pkg::in_item_t             in_item_i = '0;
  logic                          res_valid_o;
  mlc_pkg::out_item_t            res_o;
  logic                          cfg_we_i = 1'b0;
  logic [1:0]                    cfg_idx_i = '0;
  logic [mlc_pkg::CoordBits-1:0] cfg_data_i = '0;

  // Predictor copy of the clip rectangle.
  longint rect_min_x, rect_min_y, rect_max_x, rect_max_y;
  mlc_pkg::out_item_t expected_words[$];
  int  error_count = 0;
  bit  burst_on = 1'b1;
  int  burst_left = 0;

  midpoint_line_clipper_top DUT (
    .clk_i, .rst_ni, .start, .busy, .in_item_i, .res_valid_o, .res_o,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  always #4 clk_i = ~clk_i;

  // Midpoint truncated toward zero, as integer division does.
  function automatic longint mid_of(longint a, longint b);
    return (a + b) / 2;
  endfunction

  function automatic bit is_outside(longint x, longint y);
    return x < rect_min_x || x > rect_max_x || y < rect_min_y || y > rect_max_y;
  endfunction

  function automatic logic [3:0] region_code(longint x, longint y);
    logic [3:0] c;
    c = '0;
    if (x < rect_min_x) c[0] = 1'b1;
    if (x > rect_max_x) c[1] = 1'b1;
    if (y < rect_min_y) c[2] = 1'b1;
    if (y > rect_max_y) c[3] = 1'b1;
    return c;
  endfunction

  // Clamp a line with one fixed coordinate; a1/a2 run along the other axis.
  function automatic bit clamp_axis(longint f, longint fmin, longint fmax,
                                    inout longint a1, inout longint a2,
                                    input longint amin, input longint amax);
    if (f < fmin || f > fmax) return 1'b0;
    if (a1 < a2) begin
      if (a1 > amax || a2 < amin) return 1'b0;
      if (a1 < amin) a1 = amin;
      if (a2 > amax) a2 = amax;
    end else begin
      if (a2 > amax || a1 < amin) return 1'b0;
      if (a2 < amin) a2 = amin;
      if (a1 > amax) a1 = amax;
    end
    return 1'b1;
  endfunction

  // Search from the inside point toward the outside one; returns the last inside point.
  task automatic find_border(inout longint ix, inout longint iy,
                             input longint ox, input longint oy);
    longint mx, my, px, py;
    mx = mid_of(ix, ox);
    my = mid_of(iy, oy);
    for (int n = 0; n < mlc_pkg::BisectLimit; n++) begin
      if (is_outside(mx, my)) begin
        ox = mx; oy = my;
      end else begin
        ix = mx; iy = my;
      end
      px = mx; py = my;
      mx = mid_of(ix, ox);
      my = mid_of(iy, oy);
      if (mx == px && my == py) break;
    end
  endtask

  task automatic clip_line(inout longint ax, inout longint ay, inout longint bx,
                           inout longint by, input int depth, output bit vis);
    logic [3:0] c1, c2;
    longint mx, my, h1ax, h1ay, h1bx, h1by, h2ax, h2ay, h2bx, h2by;
    longint ix, iy;
    bit v1, v2;
    if (ax == bx) begin
      vis = clamp_axis(ax, rect_min_x, rect_max_x, ay, by, rect_min_y, rect_max_y);
      return;
    end
    if (ay == by) begin
      vis = clamp_axis(ay, rect_min_y, rect_max_y, ax, bx, rect_min_x, rect_max_x);
      return;
    end
    c1 = region_code(ax, ay);
    c2 = region_code(bx, by);
    if (c1 == 0 && c2 == 0) begin
      vis = 1'b1; return;
    end
    if ((c1 & c2) != 0) begin
      vis = 1'b0; return;
    end
    if (c1 != 0 && c2 != 0) begin
      mx = mid_of(ax, bx);
      my = mid_of(ay, by);
      // A split that does not shrink the segment, or one past the stack depth, is rejected.
      if ((mx == ax && my == ay) || (mx == bx && my == by) ||
          depth >= mlc_pkg::StackDepth) begin
        vis = 1'b0; return;
      end
      h1ax = ax; h1ay = ay; h1bx = mx; h1by = my;
      h2ax = mx; h2ay = my; h2bx = bx; h2by = by;
      clip_line(h1ax, h1ay, h1bx, h1by, depth + 1, v1);
      clip_line(h2ax, h2ay, h2bx, h2by, depth + 1, v2);
      if (v1 && v2) begin
        ax = h1ax; ay = h1ay; bx = h2bx; by = h2by;
      end else if (v1) begin
        ax = h1ax; ay = h1ay; bx = h1bx; by = h1by;
      end else if (v2) begin
        ax = h2ax; ay = h2ay; bx = h2bx; by = h2by;
      end
      vis = v1 || v2;
      return;
    end
    // The last inside point of the border search replaces the outside end.
    if (c1 != 0) begin
      ix = bx; iy = by; find_border(ix, iy, ax, ay); ax = ix; ay = iy;
    end else begin
      ix = ax; iy = ay; find_border(ix, iy, bx, by); bx = ix; by = iy;
    end
    vis = 1'b1;
  endtask

  task automatic predict_clip(input mlc_pkg::in_item_t it, output mlc_pkg::out_item_t r);
    longint ax, ay, bx, by;
    bit vis;
    ax = it.start_x; ay = it.start_y; bx = it.end_x; by = it.end_y;
    clip_line(ax, ay, bx, by, 0, vis);
    r.visible = vis;
    if (vis) begin
      r.clipped_start_x = mlc_pkg::coord_t'(ax); r.clipped_start_y = mlc_pkg::coord_t'(ay);
      r.clipped_end_x = mlc_pkg::coord_t'(bx);   r.clipped_end_y = mlc_pkg::coord_t'(by);
    end else begin
      r.clipped_start_x = it.start_x; r.clipped_start_y = it.start_y;
      r.clipped_end_x = it.end_x;     r.clipped_end_y = it.end_y;
    end
  endtask

  // Issue one line, holding start until the block takes it.
  task automatic send_line(mlc_pkg::coord_t sx, mlc_pkg::coord_t sy,
                           mlc_pkg::coord_t ex, mlc_pkg::coord_t ey);
    mlc_pkg::in_item_t  it;
    mlc_pkg::out_item_t exp_word;
    it = '{start_x: sx, start_y: sy, end_x: ex, end_y: ey};
    if (burst_left == 0) begin
      burst_on = !burst_on;
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    if (!burst_on) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    in_item_i <= it;
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
    predict_clip(it, exp_word);
    expected_words.push_back(exp_word);
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (expected_words.size() != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
  endtask

  task automatic write_reg(mlc_pkg::cfg_idx_e idx, mlc_pkg::coord_t val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    case (idx)
      mlc_pkg::CfgMinX: rect_min_x = val;
      mlc_pkg::CfgMinY: rect_min_y = val;
      mlc_pkg::CfgMaxX: rect_max_x = val;
      default: rect_max_y = val;
    endcase
  endtask

  task automatic set_rect(mlc_pkg::coord_t x0, mlc_pkg::coord_t y0,
                          mlc_pkg::coord_t x1, mlc_pkg::coord_t y1);
    drain_results();
    write_reg(mlc_pkg::CfgMinX, x0);
    write_reg(mlc_pkg::CfgMinY, y0);
    write_reg(mlc_pkg::CfgMaxX, x1);
    write_reg(mlc_pkg::CfgMaxY, y1);
    cfg_we_i <= 1'b0;
  endtask

  function automatic mlc_pkg::coord_t rand_coord();
    case ($urandom_range(0, 3))
      0: return mlc_pkg::coord_t'($urandom);
      1: return mlc_pkg::coord_t'($urandom_range(0, 1) ? 16'sh7fff : 16'sh8000);
      default: return mlc_pkg::coord_t'(int'($urandom_range(0, 1600)) - 500);
    endcase
  endfunction

  // Directed lines: extremes, axis-parallel, point, inside, trivial reject, splits.
  task automatic test_directed();
    send_line(16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff);
    send_line(16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff);
    send_line(100, -50, 100, 900);
    send_line(100, 900, 100, -50);
    send_line(-50, 200, 900, 200);
    send_line(900, 200, -50, 200);
    send_line(700, 10, 700, 20);
    send_line(10, 500, 20, 500);
    send_line(50, 50, 50, 50);
    send_line(-5, -5, -5, -5);
    send_line(10, 20, 600, 400);
    send_line(-10, -20, -30, 400);
    send_line(-100, 50, 300, 300);
    send_line(300, 300, 1000, 700);
    send_line(-100, 240, 800, 250);
    send_line(-1, 481, 1, 479);
    send_line(-1, -1, 1, 1);
    send_line(0, 0, 639, 479);
    send_line(-1000, 2000, 2000, -1000);
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) send_line(rand_coord(), rand_coord(), rand_coord(),
                                          rand_coord());
  endtask

  // Rectangles: full range, tiny, a single point, inverted and a wide offset one.
  task automatic test_rectangles();
    set_rect(16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff);
    test_random(100);
    set_rect(-20, -10, 30, 40);
    test_random(100);
    set_rect(5, 5, 5, 5);
    test_random(40);
    set_rect(300, 0, 100, 479);
    test_random(40);
    set_rect(-700, -300, 250, 900);
    test_directed();
    test_random(100);
  endtask

  // Compare each strobed word with the oldest expectation.
  always @(posedge clk_i) begin
    mlc_pkg::out_item_t e;
    if (rst_ni && res_valid_o) begin
      if (expected_words.size() == 0) begin
        $error("unexpected result word %h", res_o);
        error_count++;
      end else begin
        e = expected_words.pop_front();
        if (res_o.visible !== e.visible) begin
          $error("visible exp %0d got %0d", e.visible, res_o.visible); error_count++;
        end
        if (res_o.clipped_start_x !== e.clipped_start_x) begin
          $error("clipped_start_x exp %0d got %0d", e.clipped_start_x,
                 res_o.clipped_start_x); error_count++;
        end
        if (res_o.clipped_start_y !== e.clipped_start_y) begin
          $error("clipped_start_y exp %0d got %0d", e.clipped_start_y,
                 res_o.clipped_start_y); error_count++;
        end
        if (res_o.clipped_end_x !== e.clipped_end_x) begin
          $error("clipped_end_x exp %0d got %0d", e.clipped_end_x,
                 res_o.clipped_end_x); error_count++;
        end
        if (res_o.clipped_end_y !== e.clipped_end_y) begin
          $error("clipped_end_y exp %0d got %0d", e.clipped_end_y,
                 res_o.clipped_end_y); error_count++;
        end
      end
    end
  end

  initial begin
    rect_min_x = mlc_pkg::ResetMinX; rect_min_y = mlc_pkg::ResetMinY;
    rect_max_x = mlc_pkg::ResetMaxX; rect_max_y = mlc_pkg::ResetMaxY;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random(150);
    test_rectangles();
    drain_results();
    if (error_count == 0 && expected_words.size() == 0) begin
      $display("midpoint_line_clipper_top_tb OK");
    end else begin
      $display("midpoint_line_clipper_top_tb NOT OK");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run.
  initial begin
    #20ms;
    $display("midpoint_line_clipper_top_tb NOT OK");
    $finish;
  end

endmodule

`default_nettype wire
